[design/msk_pkg.sv]
// ----------------------------------------------------------------------------
// Minimum-tracking stack package
// Shared widths, codes and word types for the minimum-tracking stack.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package msk_pkg;

    // Field widths.
    localparam int VAL_W  = 32;
    localparam int WORD_W = 34;
    localparam int CNT_W  = 11;
    localparam int STATUS_W = 2;

    // Default number of stack entries.
    localparam int STACK_DEPTH_DEFAULT = 1024;

    // Operation codes.
    localparam logic ACT_PUSH = 1'b0;
    localparam logic ACT_POP  = 1'b1;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    // One input word.
    typedef struct packed {
        logic                    action;
        logic signed [VAL_W-1:0] value;
    } t_in_word;

    // One result word.
    typedef struct packed {
        logic signed [VAL_W-1:0] top_value;
        logic signed [VAL_W-1:0] min_value;
        logic [CNT_W-1:0]        entry_count;
        logic [STATUS_W-1:0]     status;
    } t_out_word;

    // Shift command broadcast along the row of cells.
    typedef struct packed {
        logic push;
        logic pop;
    } t_shift;

endpackage : msk_pkg

`default_nettype wire

[design/msk_cell.sv]
// ----------------------------------------------------------------------------
// Minimum-tracking stack cell
// Holds one encoded stack entry and moves it one place down on a push or one
// place up on a pop.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module msk_cell (
    input  wire                                   i_clk,
    input  wire msk_pkg::t_shift                  i_shift,
    input  wire logic signed [msk_pkg::WORD_W-1:0] i_from_up,
    input  wire logic signed [msk_pkg::WORD_W-1:0] i_from_down,
    output logic signed [msk_pkg::WORD_W-1:0]      o_word
);
    import msk_pkg::*;

    logic signed [WORD_W-1:0] r_word;
    logic signed [WORD_W-1:0] n_word;

    // A push takes the entry above, a pop takes the entry below.
    always_comb begin
        n_word = r_word;
        if (i_shift.push) begin
            n_word = i_from_up;
        end else if (i_shift.pop) begin
            n_word = i_from_down;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word = r_word;

endmodule : msk_cell

`default_nettype wire

[design/min_tracking_stack_core.sv]
// ----------------------------------------------------------------------------
// Minimum-tracking stack core
// LIFO stack of signed 32-bit values that reports the top, the minimum and the
// fill level after every push or pop.
// ----------------------------------------------------------------------------
// The block takes one word per clock cycle while o_in_stall is low and registers
// its result. The stack lives in a row of STACK_DEPTH cells that all shift
// together: a push moves every entry one cell down, a pop one cell up, so the
// top entry and the one below it always sit in the first two cells and no
// memory read stands between two operations. Only one running-minimum register
// is kept; entries pushed below the minimum are stored encoded as
// 2*value-min and decoded again when they are popped. A pushed word on a full
// stack and a pop on an empty stack change nothing and are flagged in status.
// Results pass through an output register and one skid word, so the input
// keeps flowing while a single result waits; the input stalls only once both
// hold a word. Entry count is reported on 11 bits.
`timescale 1ns / 1ps
`default_nettype none

module min_tracking_stack_core #(
    parameter int STACK_DEPTH = msk_pkg::STACK_DEPTH_DEFAULT
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    input  wire msk_pkg::t_in_word  i_in_data,
    output logic                 o_in_stall,
    output logic                 o_out_valid,
    output msk_pkg::t_out_word   o_out_data,
    input  wire                  i_out_stall
);
    import msk_pkg::*;

    localparam int CW    = $clog2(STACK_DEPTH + 1);
    localparam int EXT_W = WORD_W + 1;

    // Row of cells.
    logic signed [WORD_W-1:0] w_cell [STACK_DEPTH];
    logic signed [WORD_W-1:0] push_word;
    t_shift                   shift;

    // Control state.
    logic [CW-1:0]            r_count, n_count;
    logic signed [VAL_W-1:0]  r_min, n_min;

    // Output register and skid word.
    logic      r_out_valid;
    t_out_word r_out;
    logic      r_skid_valid;
    t_out_word r_skid;

    logic      accept;
    logic      take;
    t_out_word result;

    // Extended arithmetic.
    logic signed [EXT_W-1:0] v_ext, m_ext, w0_ext, w1_ext;
    logic signed [EXT_W-1:0] enc_ext, restore_ext, pop_min_ext;
    logic signed [VAL_W-1:0] pop_min, pop_top, cur_top;
    logic                    empty, full, below_min;

    assign accept = i_in_valid && !r_skid_valid;
    assign take   = r_out_valid && !i_out_stall;

    assign empty = (r_count == '0);
    assign full  = (r_count == CW'(STACK_DEPTH));

    // Encoding and decoding of the top entries against the running minimum.
    always_comb begin
        v_ext       = EXT_W'(i_in_data.value);
        m_ext       = EXT_W'(r_min);
        w0_ext      = EXT_W'(w_cell[0]);
        w1_ext      = EXT_W'(w_cell[1]);
        below_min   = v_ext < m_ext;
        enc_ext     = (v_ext <<< 1) - m_ext;
        restore_ext = (m_ext <<< 1) - w0_ext;
        pop_min     = (w0_ext < m_ext) ? restore_ext[VAL_W-1:0] : r_min;
        pop_min_ext = EXT_W'(pop_min);
        pop_top     = (w1_ext < pop_min_ext) ? pop_min : w_cell[1][VAL_W-1:0];
        cur_top     = (w0_ext < m_ext) ? r_min : w_cell[0][VAL_W-1:0];
        if (!empty && below_min) begin
            push_word = enc_ext[WORD_W-1:0];
        end else begin
            push_word = WORD_W'(i_in_data.value);
        end
    end

    // Next state, shift command and result of the accepted word.
    always_comb begin
        n_count = r_count;
        n_min   = r_min;
        shift   = '0;
        result  = '0;
        if (i_in_data.action == ACT_PUSH) begin
            if (full) begin
                result.status      = ST_FULL;
                result.top_value   = cur_top;
                result.min_value   = r_min;
                result.entry_count = CNT_W'(r_count);
            end else begin
                shift.push = accept;
                n_count    = r_count + 1'b1;
                if (empty || below_min) begin
                    n_min = i_in_data.value;
                end
                result.status      = ST_OK;
                result.top_value   = i_in_data.value;
                result.min_value   = n_min;
                result.entry_count = CNT_W'(n_count);
            end
        end else begin
            if (empty) begin
                result.status = ST_EMPTY;
            end else begin
                shift.pop          = accept;
                n_count            = r_count - 1'b1;
                n_min              = pop_min;
                result.status      = ST_OK;
                result.entry_count = CNT_W'(n_count);
                if (n_count != '0) begin
                    result.top_value = pop_top;
                    result.min_value = pop_min;
                end
            end
        end
    end

    // The chain of cells.
    for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_cell
        logic signed [WORD_W-1:0] up_word, down_word;
        if (g == 0) begin : g_first
            assign up_word = push_word;
        end else begin : g_mid_up
            assign up_word = w_cell[g-1];
        end
        if (g == STACK_DEPTH - 1) begin : g_last
            assign down_word = w_cell[g];
        end else begin : g_mid_down
            assign down_word = w_cell[g+1];
        end
        msk_cell u_cell (
            .i_clk       (i_clk),
            .i_shift     (shift),
            .i_from_up   (up_word),
            .i_from_down (down_word),
            .o_word      (w_cell[g])
        );
    end

    // Fill level and running minimum.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_min   <= '0;
        end else if (accept) begin
            r_count <= n_count;
            r_min   <= n_min;
        end
    end

    // Output register with one skid word behind it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || take) begin
            if (r_skid_valid) begin
                r_out        <= r_skid;
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out       <= result;
                r_out_valid <= accept;
            end
        end else if (accept) begin
            r_skid       <= result;
            r_skid_valid <= 1'b1;
        end
    end

    assign o_in_stall  = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule : min_tracking_stack_core

`default_nettype wire

[design/msk_checker.sv]
// ----------------------------------------------------------------------------
// Minimum-tracking stack checker
// Watches the ports of the stack core and checks the results it reports.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module msk_checker #(
    parameter int STACK_DEPTH = msk_pkg::STACK_DEPTH_DEFAULT
) (
    input wire                     i_clk,
    input wire                     i_rst_n,
    input wire                     i_in_valid,
    input wire msk_pkg::t_in_word  i_in_data,
    input wire                     o_in_stall,
    input wire                     o_out_valid,
    input wire msk_pkg::t_out_word o_out_data,
    input wire                     i_out_stall
);
    import msk_pkg::*;

    // A waiting result word stays on offer and does not change.
    a_out_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result word dropped or changed while stalled");

    // A stalled input word stays on offer and does not change.
    a_in_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_stall |=> i_in_valid && $stable(i_in_data))
        else $error("input word dropped or changed while stalled");

    // The input only stalls after a result word was held back.
    a_stall_cause : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_in_stall) |-> $past(o_out_valid && i_out_stall))
        else $error("input stalled without a held result word");

    // A refused push reports a full stack.
    a_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status == ST_FULL |->
            o_out_data.entry_count == CNT_W'(STACK_DEPTH))
        else $error("refused push on a stack that is not full");

    // An empty stack reads as zero; otherwise the top is never below the minimum.
    a_view : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            ((o_out_data.entry_count == '0) ?
                (o_out_data.top_value == '0 && o_out_data.min_value == '0) :
                (o_out_data.min_value <= o_out_data.top_value)))
        else $error("inconsistent top or minimum for the reported fill level");

endmodule : msk_checker

bind min_tracking_stack_core msk_checker #(
    .STACK_DEPTH (STACK_DEPTH)
) u_msk_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_data   (i_in_data),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .o_out_data  (o_out_data),
    .i_out_stall (i_out_stall)
);

`default_nettype wire
